[design/dsi_pkg.sv]
`timescale 1ns / 1ps

package dsi_pkg;

    localparam int FRAC_BITS_DEF    = 12;
    localparam int MAX_SUBSTEPS_DEF = 8;

    localparam int OMEGA_W = 15;
    localparam int IN_W    = 16;
    localparam int RESP_W  = 13;
    localparam int RATE_W  = 16;
    localparam int DT_W    = 15;

    localparam int DT_DEFAULT = 1049;
    localparam int DT_LIMIT   = 16384;
    localparam int K060_Q15   = 19661;
    localparam int K065_Q15   = 21299;
    localparam int ONE_Q15    = 32768;

    localparam int APB_DW = 32;
    localparam int APB_AW = 3;
    localparam logic [APB_AW-3:0] REG_OMEGA = '0;

    typedef logic [4:0] t_upc;

    localparam t_upc U_IDLE  = 5'd0;
    localparam t_upc U_MGUST = 5'd1;
    localparam t_upc U_MEVT  = 5'd2;
    localparam t_upc U_MWW   = 5'd3;
    localparam t_upc U_MAB   = 5'd4;
    localparam t_upc U_MWC   = 5'd5;
    localparam t_upc U_MWDT  = 5'd6;
    localparam t_upc U_STEPS = 5'd7;
    localparam t_upc U_DIV   = 5'd8;
    localparam t_upc U_SDIFF = 5'd9;
    localparam t_upc U_SCQD  = 5'd10;
    localparam t_upc U_SACC  = 5'd11;
    localparam t_upc U_SACCH = 5'd12;
    localparam t_upc U_SQD   = 5'd13;
    localparam t_upc U_SQDH  = 5'd14;
    localparam t_upc U_SQ    = 5'd15;
    localparam t_upc U_CLAMP = 5'd16;
    localparam t_upc U_DONE  = 5'd17;

    typedef enum logic [3:0] {
        MOP_NONE  = 4'd0,
        MOP_GUST  = 4'd1,
        MOP_EVENT = 4'd2,
        MOP_WW    = 4'd3,
        MOP_AB    = 4'd4,
        MOP_WC    = 4'd5,
        MOP_WDT   = 4'd6,
        MOP_DIFF  = 4'd7,
        MOP_CQD   = 4'd8,
        MOP_ACCH  = 4'd9,
        MOP_QDH   = 4'd10
    } t_mop;

    typedef enum logic [3:0] {
        WOP_NONE  = 4'd0,
        WOP_A     = 4'd1,
        WOP_B     = 4'd2,
        WOP_W2    = 4'd3,
        WOP_TGT   = 4'd4,
        WOP_C     = 4'd5,
        WOP_STEPS = 4'd6,
        WOP_DIV   = 4'd7,
        WOP_SAVE  = 4'd8,
        WOP_ACC   = 4'd9,
        WOP_QD    = 4'd10,
        WOP_Q     = 4'd11,
        WOP_CLAMP = 4'd12
    } t_wop;

    typedef enum logic [2:0] {
        SEQ_NEXT     = 3'd0,
        SEQ_JUMP     = 3'd1,
        SEQ_WAIT_IN  = 3'd2,
        SEQ_REPEAT   = 3'd3,
        SEQ_LOOP     = 3'd4,
        SEQ_WAIT_OUT = 3'd5
    } t_seq;

    typedef struct packed {
        t_mop mop;
        t_wop wop;
        t_seq seq;
        t_upc target;
    } t_uword;

    typedef struct packed {
        t_mop mop;
        t_wop wop;
        logic load;
    } t_dp_ctrl;

    typedef struct packed {
        logic last_sub;
    } t_dp_status;

    function automatic t_uword ucode(input t_upc upc);
        t_uword w;
        w = '{mop: MOP_NONE, wop: WOP_NONE, seq: SEQ_NEXT, target: U_IDLE};
        unique case (upc)
            U_IDLE: begin
                w.seq    = SEQ_WAIT_IN;
                w.target = U_DONE;
            end
            U_MGUST: w.mop = MOP_GUST;
            U_MEVT: begin
                w.mop = MOP_EVENT;
                w.wop = WOP_A;
            end
            U_MWW: begin
                w.mop = MOP_WW;
                w.wop = WOP_B;
            end
            U_MAB: begin
                w.mop = MOP_AB;
                w.wop = WOP_W2;
            end
            U_MWC: begin
                w.mop = MOP_WC;
                w.wop = WOP_TGT;
            end
            U_MWDT: begin
                w.mop = MOP_WDT;
                w.wop = WOP_C;
            end
            U_STEPS: w.wop = WOP_STEPS;
            U_DIV: begin
                w.wop = WOP_DIV;
                w.seq = SEQ_REPEAT;
            end
            U_SDIFF: w.mop = MOP_DIFF;
            U_SCQD: begin
                w.mop = MOP_CQD;
                w.wop = WOP_SAVE;
            end
            U_SACC: w.wop = WOP_ACC;
            U_SACCH: w.mop = MOP_ACCH;
            U_SQD: w.wop = WOP_QD;
            U_SQDH: w.mop = MOP_QDH;
            U_SQ: begin
                w.wop    = WOP_Q;
                w.seq    = SEQ_LOOP;
                w.target = U_SDIFF;
            end
            U_CLAMP: w.wop = WOP_CLAMP;
            U_DONE: begin
                w.seq    = SEQ_WAIT_OUT;
                w.target = U_IDLE;
            end
            default: begin
                w.seq    = SEQ_JUMP;
                w.target = U_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

[design/dsi_if.sv]
`timescale 1ns / 1ps

interface dsi_in_if;
    logic                      valid;
    logic                      ready;
    logic [dsi_pkg::IN_W-1:0]  gust_sample;
    logic [dsi_pkg::IN_W-1:0]  gust_event;
    logic [dsi_pkg::IN_W-1:0]  frame_time;

    modport source (output valid, gust_sample, gust_event, frame_time, input ready);
    modport sink (input valid, gust_sample, gust_event, frame_time, output ready);
endinterface

interface dsi_out_if;
    logic                               valid;
    logic                               ready;
    logic [dsi_pkg::RESP_W-1:0]         sway_response;
    logic signed [dsi_pkg::RATE_W-1:0]  sway_rate;

    modport source (output valid, sway_response, sway_rate, input ready);
    modport sink (input valid, sway_response, sway_rate, output ready);
endinterface

[design/dsi_datapath.sv]
`timescale 1ns / 1ps

module dsi_datapath #(
    parameter int FRAC_BITS    = dsi_pkg::FRAC_BITS_DEF,
    parameter int MAX_SUBSTEPS = dsi_pkg::MAX_SUBSTEPS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dsi_pkg::t_dp_ctrl                   i_ctrl,
    input  logic [dsi_pkg::OMEGA_W-1:0]         i_omega,
    input  logic [dsi_pkg::IN_W-1:0]            i_gust,
    input  logic [dsi_pkg::IN_W-1:0]            i_event,
    input  logic [dsi_pkg::IN_W-1:0]            i_dt,
    output dsi_pkg::t_dp_status                 o_status,
    output logic [dsi_pkg::RESP_W-1:0]          o_resp,
    output logic signed [dsi_pkg::RATE_W-1:0]   o_rate
);

    localparam int A_W    = 32;
    localparam int B_W    = (32 - FRAC_BITS > 18) ? 32 - FRAC_BITS : 18;
    localparam int P_W    = A_W + B_W;
    localparam int Q_W    = (FRAC_BITS + 2 > 16) ? FRAC_BITS + 2 : 16;
    localparam int STEP_W = $clog2(MAX_SUBSTEPS + 1);
    localparam int DT_W   = dsi_pkg::DT_W;
    localparam int TSH    = 30 - FRAC_BITS;

    localparam int RESP_LO_I = (35 * (2 ** FRAC_BITS) + 50) / 100;
    localparam int RESP_HI_I = (160 * (2 ** FRAC_BITS) + 50) / 100;
    localparam logic signed [Q_W-1:0] RESP_LO = Q_W'(RESP_LO_I);
    localparam logic signed [Q_W-1:0] RESP_HI = Q_W'(RESP_HI_I);
    localparam logic signed [P_W-1:0] SAT_HI  = P_W'(32767);
    localparam logic signed [P_W-1:0] SAT_LO  = P_W'(-32768);

    function automatic logic signed [P_W-1:0] rnd_shr(input logic signed [P_W-1:0] x,
                                                      input int s);
        logic signed [P_W-1:0] half;
        half = P_W'(1) <<< (s - 1);
        return (x + half) >>> s;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [P_W-1:0] x);
        logic signed [15:0] y;
        if (x > SAT_HI) begin
            y = 16'sh7fff;
        end else if (x < SAT_LO) begin
            y = 16'sh8000;
        end else begin
            y = x[15:0];
        end
        return y;
    endfunction

    logic [dsi_pkg::IN_W-1:0]  r_gust;
    logic [dsi_pkg::IN_W-1:0]  r_event;
    logic [DT_W-1:0]           r_dt;
    logic signed [P_W-1:0]     r_p;
    logic signed [P_W-1:0]     r_s;
    logic [16:0]               r_a;
    logic [16:0]               r_b;
    logic signed [B_W-1:0]     r_w2;
    logic signed [A_W-1:0]     r_tgt;
    logic [14:0]               r_c;
    logic signed [A_W-1:0]     r_acc;
    logic [STEP_W-1:0]         r_ns;
    logic [STEP_W-1:0]         r_rem;
    logic [DT_W-1:0]           r_quo;
    logic signed [Q_W-1:0]     r_q;
    logic signed [15:0]        r_qd;
    logic                      r_init;

    logic signed [A_W-1:0]     op_a;
    logic signed [B_W-1:0]     op_b;
    logic signed [P_W-1:0]     prod;
    logic signed [A_W-1:0]     diff;
    logic signed [P_W-1:0]     p_r15;
    logic signed [P_W-1:0]     p_rf;
    logic signed [P_W-1:0]     p_rt;
    logic signed [P_W-1:0]     p_r16;
    logic signed [P_W-1:0]     acc_full;
    logic signed [P_W-1:0]     sh;
    logic signed [P_W-1:0]     steps_p1;
    logic signed [15:0]        qd_new;
    logic signed [15:0]        q_new;
    logic signed [15:0]        tgt_sat;
    logic [STEP_W:0]           div_tr;
    logic                      div_ge;
    logic [DT_W-1:0]           dt_fix;

    assign diff = r_tgt - A_W'(r_q);

    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (i_ctrl.mop)
            dsi_pkg::MOP_GUST: begin
                op_a = A_W'(r_gust);
                op_b = B_W'(dsi_pkg::K065_Q15);
            end
            dsi_pkg::MOP_EVENT: begin
                op_a = A_W'(r_event);
                op_b = B_W'(dsi_pkg::K060_Q15);
            end
            dsi_pkg::MOP_WW: begin
                op_a = A_W'(i_omega);
                op_b = B_W'(i_omega);
            end
            dsi_pkg::MOP_AB: begin
                op_a = A_W'(r_b);
                op_b = B_W'(r_a);
            end
            dsi_pkg::MOP_WC: begin
                op_a = A_W'(i_omega);
                op_b = B_W'(dsi_pkg::K060_Q15);
            end
            dsi_pkg::MOP_WDT: begin
                op_a = A_W'(r_dt);
                op_b = B_W'(i_omega);
            end
            dsi_pkg::MOP_DIFF: begin
                op_a = diff;
                op_b = r_w2;
            end
            dsi_pkg::MOP_CQD: begin
                op_a = A_W'(r_qd);
                op_b = B_W'(r_c);
            end
            dsi_pkg::MOP_ACCH: begin
                op_a = r_acc;
                op_b = B_W'(r_quo);
            end
            dsi_pkg::MOP_QDH: begin
                op_a = A_W'(r_qd);
                op_b = B_W'(r_quo);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod = op_a * op_b;

    always_comb begin
        p_r15    = rnd_shr(r_p, 15);
        p_rf     = rnd_shr(r_p, FRAC_BITS);
        p_rt     = rnd_shr(r_p, TSH);
        p_r16    = rnd_shr(r_p, 16);
        acc_full = rnd_shr(r_s - r_p, FRAC_BITS);
        sh       = r_p >>> (14 + FRAC_BITS);
        steps_p1 = sh + P_W'(1);
        qd_new   = sat16(P_W'(r_qd) + p_r16);
        q_new    = sat16(P_W'(r_q) + p_r16);
        tgt_sat  = sat16(p_rt);
        div_tr   = {r_rem, r_quo[DT_W-1]};
        div_ge   = (div_tr >= {1'b0, r_ns});
        if ((i_dt == '0) || (i_dt > dsi_pkg::IN_W'(dsi_pkg::DT_LIMIT))) begin
            dt_fix = DT_W'(dsi_pkg::DT_DEFAULT);
        end else begin
            dt_fix = i_dt[DT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q    <= '0;
            r_qd   <= '0;
            r_init <= 1'b0;
        end else begin
            case (i_ctrl.wop)
                dsi_pkg::WOP_TGT: begin
                    if (!r_init) begin
                        r_q    <= Q_W'(tgt_sat);
                        r_qd   <= '0;
                        r_init <= 1'b1;
                    end
                end
                dsi_pkg::WOP_QD: r_qd <= qd_new;
                dsi_pkg::WOP_Q: r_q <= Q_W'(q_new);
                dsi_pkg::WOP_CLAMP: begin
                    if (r_q < RESP_LO) begin
                        r_q <= RESP_LO;
                    end else if (r_q > RESP_HI) begin
                        r_q <= RESP_HI;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_gust  <= i_gust;
            r_event <= i_event;
            r_dt    <= dt_fix;
        end
        if (i_ctrl.mop != dsi_pkg::MOP_NONE) begin
            r_p <= prod;
        end
        case (i_ctrl.wop)
            dsi_pkg::WOP_A: r_a <= 17'(p_r15 + P_W'(dsi_pkg::K060_Q15));
            dsi_pkg::WOP_B: r_b <= 17'(p_r15 + P_W'(dsi_pkg::ONE_Q15));
            dsi_pkg::WOP_W2: r_w2 <= p_rf[B_W-1:0];
            dsi_pkg::WOP_TGT: r_tgt <= p_rt[A_W-1:0];
            dsi_pkg::WOP_C: r_c <= p_r15[14:0];
            dsi_pkg::WOP_STEPS: begin
                if (sh >= P_W'(MAX_SUBSTEPS)) begin
                    r_ns <= STEP_W'(MAX_SUBSTEPS);
                end else begin
                    r_ns <= steps_p1[STEP_W-1:0];
                end
                r_rem <= '0;
                r_quo <= r_dt;
            end
            dsi_pkg::WOP_DIV: begin
                if (div_ge) begin
                    r_rem <= STEP_W'(div_tr - {1'b0, r_ns});
                    r_quo <= {r_quo[DT_W-2:0], 1'b1};
                end else begin
                    r_rem <= div_tr[STEP_W-1:0];
                    r_quo <= {r_quo[DT_W-2:0], 1'b0};
                end
            end
            dsi_pkg::WOP_SAVE: r_s <= r_p;
            dsi_pkg::WOP_ACC: r_acc <= acc_full[A_W-1:0];
            dsi_pkg::WOP_Q: r_ns <= r_ns - STEP_W'(1);
            default: begin
            end
        endcase
    end

    assign o_status.last_sub = (r_ns == STEP_W'(1));
    assign o_resp            = r_q[dsi_pkg::RESP_W-1:0];
    assign o_rate            = r_qd;

endmodule

[design/damped_sway_integrator_core.sv]
`timescale 1ns / 1ps

// Channel   Direction  Payload                                   Handshake
// i_in      in         gust_sample, gust_event, frame_time        valid/ready
// o_out     out        sway_response, sway_rate                   valid/ready
// apb       in         natural_omega at byte address 0            psel/penable, pready high
//
// An integrating transaction runs from acceptance to result through the coefficient steps, the
// 15-step restoring divider for the substep length and S passes of the seven-step substep loop
// on the shared multiplier, S being the substep count (1 to MAX_SUBSTEPS). With natural_omega
// at zero the sequencer goes from its input wait straight to the result step.
// Reset is synchronous; it clears the sequencer, the output valid flag and the sway state.
// A result held by a stalled output only holds the sequencer at its last step.

module damped_sway_integrator_core #(
    parameter int FRAC_BITS    = dsi_pkg::FRAC_BITS_DEF,
    parameter int MAX_SUBSTEPS = dsi_pkg::MAX_SUBSTEPS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    dsi_in_if.sink                         i_in,
    dsi_out_if.source                      o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dsi_pkg::APB_AW-1:0]     paddr,
    input  logic [dsi_pkg::APB_DW-1:0]     pwdata,
    output logic [dsi_pkg::APB_DW-1:0]     prdata,
    output logic                           pready
);

    localparam int CNT_W = $clog2(dsi_pkg::DT_W);

    dsi_pkg::t_upc                      r_upc;
    dsi_pkg::t_upc                      n_upc;
    logic [CNT_W-1:0]                   r_cnt;
    logic [CNT_W-1:0]                   n_cnt;
    logic [dsi_pkg::OMEGA_W-1:0]        r_omega;
    logic                               r_out_valid;
    logic [dsi_pkg::RESP_W-1:0]         r_resp;
    logic signed [dsi_pkg::RATE_W-1:0]  r_rate;

    dsi_pkg::t_uword                    uw;
    dsi_pkg::t_dp_ctrl                  dp_ctrl;
    dsi_pkg::t_dp_status                dp_status;
    logic [dsi_pkg::RESP_W-1:0]         dp_resp;
    logic signed [dsi_pkg::RATE_W-1:0]  dp_rate;
    logic                               in_acc;
    logic                               out_free;
    logic                               out_load;
    logic                               cfg_wr;
    logic [dsi_pkg::APB_AW-3:0]         cfg_idx;

    assign uw         = dsi_pkg::ucode(r_upc);
    assign i_in.ready = (uw.seq == dsi_pkg::SEQ_WAIT_IN);
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;

    always_comb begin
        n_upc    = r_upc;
        n_cnt    = r_cnt;
        out_load = 1'b0;
        unique case (uw.seq)
            dsi_pkg::SEQ_NEXT: n_upc = r_upc + dsi_pkg::t_upc'(1);
            dsi_pkg::SEQ_JUMP: n_upc = uw.target;
            dsi_pkg::SEQ_WAIT_IN: begin
                if (in_acc) begin
                    n_upc = (r_omega == '0) ? uw.target : r_upc + dsi_pkg::t_upc'(1);
                end
            end
            dsi_pkg::SEQ_REPEAT: begin
                if (r_cnt == CNT_W'(dsi_pkg::DT_W - 1)) begin
                    n_cnt = '0;
                    n_upc = r_upc + dsi_pkg::t_upc'(1);
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            dsi_pkg::SEQ_LOOP: begin
                n_upc = dp_status.last_sub ? r_upc + dsi_pkg::t_upc'(1) : uw.target;
            end
            dsi_pkg::SEQ_WAIT_OUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_upc    = uw.target;
                end
            end
            default: n_upc = dsi_pkg::U_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= dsi_pkg::U_IDLE;
            r_cnt <= '0;
        end else begin
            r_upc <= n_upc;
            r_cnt <= n_cnt;
        end
    end

    assign dp_ctrl.mop  = uw.mop;
    assign dp_ctrl.wop  = uw.wop;
    assign dp_ctrl.load = in_acc;

    dsi_datapath #(
        .FRAC_BITS    (FRAC_BITS),
        .MAX_SUBSTEPS (MAX_SUBSTEPS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (dp_ctrl),
        .i_omega  (r_omega),
        .i_gust   (i_in.gust_sample),
        .i_event  (i_in.gust_event),
        .i_dt     (i_in.frame_time),
        .o_status (dp_status),
        .o_resp   (dp_resp),
        .o_rate   (dp_rate)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_resp <= dp_resp;
            r_rate <= dp_rate;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.sway_response = r_resp;
    assign o_out.sway_rate     = r_rate;

    assign cfg_idx = paddr[dsi_pkg::APB_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_omega <= '0;
        end else if (cfg_wr && (cfg_idx == dsi_pkg::REG_OMEGA)) begin
            r_omega <= pwdata[dsi_pkg::OMEGA_W-1:0];
        end
    end

    assign prdata = (cfg_idx == dsi_pkg::REG_OMEGA) ? dsi_pkg::APB_DW'(r_omega) : '0;

endmodule

[design/dsi_checker.sv]
`timescale 1ns / 1ps

module dsi_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [dsi_pkg::RESP_W-1:0]     i_out_resp,
    input logic [dsi_pkg::RATE_W-1:0]     i_out_rate
);

    // Only one transaction is in work at a time, so input is refused right after acceptance.
    a_in_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input accepted again right after a transaction");

    // A result appears only after the sequencer has left its input wait.
    a_out_late: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result presented while the input was still being taken");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("stalled result dropped");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> ($stable(i_out_resp) && $stable(i_out_rate)))
        else $error("stalled result changed");

endmodule

bind damped_sway_integrator_core dsi_checker u_dsi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_resp  (o_out.sway_response),
    .i_out_rate  (o_out.sway_rate)
);
